// ===== src/mact_pkg.sv =====
`default_nettype none

package mact_pkg;

   localparam int PRICE_FIELD_BITS = 32;
   localparam int AVG_FIELD_BITS   = 32;
   localparam int PROFIT_BITS      = 48;
   localparam int WINDOW_CFG_BITS  = 7;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int RSP_TDATA_BITS   = 2 * AVG_FIELD_BITS + PROFIT_BITS;
   localparam int RSP_TUSER_BITS   = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_WINDOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECOND_WINDOW = 2'd1;

   localparam logic [WINDOW_CFG_BITS-1:0] FIRST_WINDOW_RESET  = 7'd2;
   localparam logic [WINDOW_CFG_BITS-1:0] SECOND_WINDOW_RESET = 7'd7;

   localparam logic [1:0] SIGN_ZERO = 2'd0;
   localparam logic [1:0] SIGN_POS  = 2'd1;
   localparam logic [1:0] SIGN_NEG  = 2'd2;

   localparam logic [1:0] CROSS_NONE = 2'd0;
   localparam logic [1:0] CROSS_UP   = 2'd1;
   localparam logic [1:0] CROSS_DOWN = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ACCUM,
      ST_DIVIDE,
      ST_FINISH
   } mact_state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic read;
      logic div_start;
      logic commit;
   } mact_cmd_type;

   typedef struct packed {
      logic reads_done;
      logic accum_done;
      logic div_done;
   } mact_status_type;

endpackage

`default_nettype wire

// ===== src/moving_average_crossover_tracker_unit.sv =====
// channel   | direction | handshake            | payload
// request   | in        | req_tvalid/tready    | req_tdata: price
// response  | out       | rsp_tvalid/tready    | rsp_tdata, rsp_tuser
// csr       | in        | csr_valid/csr_ready  | csr_index, csr_data: window lengths
//
// one request at a time: wl history reads on the single memory read port,
// then two bit-serial dividers in parallel, one quotient bit per cycle
// a new request is taken while the previous response still waits in its register
// synchronous active-high reset; history memory needs no clearing pass
`default_nettype none

module moving_average_crossover_tracker_unit #(
   parameter int MAX_WINDOW = 64,
   parameter int PRICE_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [mact_pkg::PRICE_FIELD_BITS-1:0] req_tdata,   // price
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // short_average, long_average, profit_total
   output logic [mact_pkg::RSP_TDATA_BITS-1:0]        rsp_tdata,
   output logic [mact_pkg::RSP_TUSER_BITS-1:0]        rsp_tuser,   // cross_kind, pair_closed
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [mact_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mact_pkg::WINDOW_CFG_BITS-1:0]  csr_data
);

   import mact_pkg::*;

   mact_cmd_type    cmd;
   mact_status_type status;

   assign csr_ready = 1'b1;

   mact_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mact_dp #(
      .MAX_WINDOW (MAX_WINDOW),
      .PRICE_BITS (PRICE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== src/mact_div.sv =====
`default_nettype none

module mact_div #(
   parameter int DW = 39,
   parameter int VW = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic      [DW-1:0] quotient,
   output logic               busy
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] dq_ff, dq_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] step_ff, step_in;
   logic          busy_ff, busy_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          ge;

   always_comb begin
      trial = {rem_ff, dq_ff[DW-1]};
      ge    = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         dq_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dq_in   = {dq_ff[DW-2:0], ge};
         rem_in  = ge ? diff[VW-1:0] : trial[VW-1:0];
         step_in = step_ff + 1'b1;
         busy_in = step_ff != CW'(DW - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = dq_ff;
   assign busy     = busy_ff;

endmodule

`default_nettype wire

// ===== src/mact_dp.sv =====
`default_nettype none

module mact_dp #(
   parameter int MAX_WINDOW = 64,
   parameter int PRICE_BITS = 32
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     csr_valid,
   input  wire logic [mact_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire logic [mact_pkg::WINDOW_CFG_BITS-1:0]     csr_data,
   input  wire logic [mact_pkg::PRICE_FIELD_BITS-1:0]    req_tdata,
   input  wire mact_pkg::mact_cmd_type                   cmd,
   output mact_pkg::mact_status_type                     status,
   output logic [mact_pkg::RSP_TDATA_BITS-1:0]           rsp_tdata,
   output logic [mact_pkg::RSP_TUSER_BITS-1:0]           rsp_tuser
);

   import mact_pkg::*;

   localparam int PW = (PRICE_BITS < PRICE_FIELD_BITS) ? PRICE_BITS : PRICE_FIELD_BITS;
   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WW = $clog2(MAX_WINDOW + 1);
   localparam int SW = PW + WW;

   function automatic logic [WW-1:0] clamp_window(input logic [WINDOW_CFG_BITS-1:0] w);
      logic [31:0] wx;
      logic [WW-1:0] r;
      wx = 32'(w);
      if (wx == 32'd0) begin
         r = WW'(1);
      end else if (wx > 32'(MAX_WINDOW)) begin
         r = WW'(MAX_WINDOW);
      end else begin
         r = WW'(wx);
      end
      return r;
   endfunction

   logic [PW-1:0] mem [MAX_WINDOW];

   logic [WINDOW_CFG_BITS-1:0] first_ff, first_in;
   logic [WINDOW_CFG_BITS-1:0] second_ff, second_in;
   logic [PW-1:0]              price_ff, price_in;
   logic [WW-1:0]              ws_ff, ws_in;
   logic [WW-1:0]              wl_ff, wl_in;
   logic [AW-1:0]              rd_idx_ff, rd_idx_in;
   logic [AW-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [WW-1:0]              cnt_ff, cnt_in;
   logic [WW-1:0]              rd_k_ff, rd_k_in;
   logic                       rd_valid_ff, rd_valid_in;
   logic [PW-1:0]              rd_data_ff;
   logic [SW-1:0]              ssum_ff, ssum_in;
   logic [SW-1:0]              lsum_ff, lsum_in;
   logic [WW-1:0]              seen_ff, seen_in;
   logic [1:0]                 sign_ff, sign_in;
   logic                       open_ff, open_in;
   logic [PW-1:0]              open_price_ff, open_price_in;
   logic [PROFIT_BITS-1:0]     profit_ff, profit_in;
   logic [1:0]                 kind_ff, kind_in;
   logic                       closed_ff, closed_in;
   logic [PW-1:0]              savg_ff, savg_in;
   logic [PW-1:0]              lavg_ff, lavg_in;

   logic [WW-1:0]          wa, wb;
   logic [SW-1:0]          squot, lquot;
   logic                   sbusy, lbusy;
   logic [1:0]             sign_now;
   logic [PW:0]            delta;
   logic [PROFIT_BITS:0]   psum;

   mact_div #(.DW(SW), .VW(WW)) u_short_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (ssum_ff),
      .divisor  (ws_ff),
      .quotient (squot),
      .busy     (sbusy)
   );

   mact_div #(.DW(SW), .VW(WW)) u_long_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (lsum_ff),
      .divisor  (wl_ff),
      .quotient (lquot),
      .busy     (lbusy)
   );

   assign status.reads_done = cnt_ff == wl_ff;
   assign status.accum_done = (cnt_ff == wl_ff) && !rd_valid_ff;
   assign status.div_done   = !sbusy && !lbusy;

   // config writes
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      if (csr_valid && csr_index == CSR_FIRST_WINDOW) begin
         first_in = csr_data;
      end
      if (csr_valid && csr_index == CSR_SECOND_WINDOW) begin
         second_in = csr_data;
      end
   end

   // window sums
   always_comb begin
      wa          = clamp_window(first_ff);
      wb          = clamp_window(second_ff);
      price_in    = cmd.capture ? req_tdata[PW-1:0] : price_ff;
      ws_in       = ws_ff;
      wl_in       = wl_ff;
      rd_idx_in   = rd_idx_ff;
      cnt_in      = cnt_ff;
      ssum_in     = ssum_ff;
      lsum_in     = lsum_ff;
      rd_valid_in = cmd.read;
      rd_k_in     = cnt_ff;
      if (cmd.load) begin
         ws_in     = (wa < wb) ? wa : wb;
         wl_in     = (wa < wb) ? wb : wa;
         rd_idx_in = (wr_ptr_ff == '0) ? AW'(MAX_WINDOW - 1) : wr_ptr_ff - 1'b1;
         cnt_in    = '0;
         ssum_in   = '0;
         lsum_in   = '0;
      end else begin
         if (cmd.read) begin
            rd_idx_in = (rd_idx_ff == '0) ? AW'(MAX_WINDOW - 1) : rd_idx_ff - 1'b1;
            cnt_in    = cnt_ff + 1'b1;
         end
         if (rd_valid_ff) begin
            lsum_in = lsum_ff + SW'(rd_data_ff);
            if (rd_k_ff < ws_ff) begin
               ssum_in = ssum_ff + SW'(rd_data_ff);
            end
         end
      end
   end

   // crossover and profit
   always_comb begin
      savg_in = (seen_ff < ws_ff) ? price_ff : squot[PW-1:0];
      lavg_in = (seen_ff < wl_ff) ? price_ff : lquot[PW-1:0];
      if (lavg_in > savg_in) begin
         sign_now = SIGN_POS;
      end else if (lavg_in < savg_in) begin
         sign_now = SIGN_NEG;
      end else begin
         sign_now = SIGN_ZERO;
      end
      if (sign_ff == SIGN_POS && sign_now == SIGN_NEG) begin
         kind_in = CROSS_UP;
      end else if (sign_ff == SIGN_NEG && sign_now == SIGN_POS) begin
         kind_in = CROSS_DOWN;
      end else begin
         kind_in = CROSS_NONE;
      end
      delta = {1'b0, open_price_ff} - {1'b0, price_ff};
      psum  = {profit_ff[PROFIT_BITS-1], profit_ff}
            + {{(PROFIT_BITS - PW){delta[PW]}}, delta};

      sign_in       = sign_ff;
      open_in       = open_ff;
      open_price_in = open_price_ff;
      profit_in     = profit_ff;
      closed_in     = closed_ff;
      wr_ptr_in     = wr_ptr_ff;
      seen_in       = seen_ff;
      if (cmd.commit) begin
         sign_in   = sign_now;
         closed_in = 1'b0;
         if (kind_in != CROSS_NONE) begin
            if (!open_ff) begin
               open_in       = 1'b1;
               open_price_in = price_ff;
            end else begin
               open_in   = 1'b0;
               closed_in = 1'b1;
               if (psum[PROFIT_BITS] != psum[PROFIT_BITS-1]) begin
                  profit_in = psum[PROFIT_BITS] ? {1'b1, {(PROFIT_BITS-1){1'b0}}}
                                                : {1'b0, {(PROFIT_BITS-1){1'b1}}};
               end else begin
                  profit_in = psum[PROFIT_BITS-1:0];
               end
            end
         end
         wr_ptr_in = (wr_ptr_ff == AW'(MAX_WINDOW - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (seen_ff != WW'(MAX_WINDOW)) begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
      if (cmd.commit) begin
         mem[wr_ptr_ff] <= price_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff      <= FIRST_WINDOW_RESET;
         second_ff     <= SECOND_WINDOW_RESET;
         wr_ptr_ff     <= '0;
         seen_ff       <= '0;
         sign_ff       <= SIGN_ZERO;
         open_ff       <= 1'b0;
         open_price_ff <= '0;
         profit_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         cnt_ff        <= '0;
         wl_ff         <= WW'(1);
         ws_ff         <= WW'(1);
      end else begin
         first_ff      <= first_in;
         second_ff     <= second_in;
         wr_ptr_ff     <= wr_ptr_in;
         seen_ff       <= seen_in;
         sign_ff       <= sign_in;
         open_ff       <= open_in;
         open_price_ff <= open_price_in;
         profit_ff     <= profit_in;
         rd_valid_ff   <= rd_valid_in;
         cnt_ff        <= cnt_in;
         wl_ff         <= wl_in;
         ws_ff         <= ws_in;
      end
      price_ff  <= price_in;
      rd_idx_ff <= rd_idx_in;
      rd_k_ff   <= rd_k_in;
      ssum_ff   <= ssum_in;
      lsum_ff   <= lsum_in;
      if (cmd.commit) begin
         kind_ff   <= kind_in;
         closed_ff <= closed_in;
         savg_ff   <= savg_in;
         lavg_ff   <= lavg_in;
      end
   end

   assign rsp_tdata = {profit_ff, AVG_FIELD_BITS'(lavg_ff), AVG_FIELD_BITS'(savg_ff)};
   assign rsp_tuser = {closed_ff, kind_ff};

   a_wr_ptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(wr_ptr_ff) < 32'(MAX_WINDOW))
      else $error("write pointer out of range");

   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      32'(seen_ff) <= 32'(MAX_WINDOW))
      else $error("items seen beyond window maximum");

   a_pair_toggle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> ((open_ff != $past(open_ff)) == (kind_ff != CROSS_NONE)))
      else $error("pair state did not follow cross");

   a_profit_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(profit_ff))
      else $error("profit changed without commit");

endmodule

`default_nettype wire

// ===== src/mact_ctrl.sv =====
`default_nettype none

module mact_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   input  wire mact_pkg::mact_status_type  status,
   output mact_pkg::mact_cmd_type          cmd
);

   import mact_pkg::*;

   mact_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (status.accum_done) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ST_ACCUM: begin
            cmd.read      = !status.reads_done;
            cmd.div_start = status.accum_done;
         end
         ST_DIVIDE: begin
         end
         ST_FINISH: begin
            cmd.commit = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire
